// ----- sv/point_splat_depth_rasterizer_top_macros.svh -----
// Assertion macros for the point splat depth rasterizer checker.
// Each macro expands to one labeled concurrent assertion on the clock named clock.
`ifndef POINT_SPLAT_DEPTH_RASTERIZER_TOP_MACROS_SVH
`define POINT_SPLAT_DEPTH_RASTERIZER_TOP_MACROS_SVH

// Implication into the next cycle, ignored while reset is high
`define PSR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

// Implication into the next cycle, checked during reset as well
`define PSR_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- sv/psr_pkg.sv -----
// Shared widths, command codes, register indexes and types of the point splat rasterizer.
// No dependencies.
package psr_pkg;

   localparam int CMD_W      = 2;
   localparam int COORD_W    = 20;
   localparam int COLOR_W    = 24;
   localparam int PIX_X_W    = 8;
   localparam int PIX_Y_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;
   localparam int DEPTH_W    = 20;
   localparam int GAIN_W     = 11;
   localparam int ZOOM_W     = 16;
   localparam int DIST_W     = 20;
   localparam int TRIG_FRAC  = 14;

   // shared multiply-accumulate and divider widths
   localparam int MAC_A_W   = 28;
   localparam int MAC_B_W   = 17;
   localparam int MAC_P_W   = MAC_A_W + MAC_B_W;
   localparam int MAC_ACC_W = MAC_P_W + 1;
   localparam int DIV_N_W   = MAC_P_W;
   localparam int DIV_D_W   = MAC_A_W - 1;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   localparam logic [DEPTH_W-1:0] DEPTH_CLEAR = 20'd256000;

   // commands
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SPLAT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_YAW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIST   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ZOOM   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS   = 3'd7;

   typedef struct packed {
      logic start;
      logic sub;
   } mac_ctl_type;

endpackage

// ----- sv/psr_if.sv -----
// Valid/ready channel interfaces: point requests, pixel responses, register writes.
// Depends on psr_pkg.
interface psr_req_if;
   import psr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic signed [COORD_W-1:0]  point_x;
   logic signed [COORD_W-1:0]  point_y;
   logic signed [COORD_W-1:0]  point_z;
   logic [COLOR_W-1:0]         point_color;
   modport source (output valid, command, point_x, point_y, point_z, point_color,
                   input ready);
   modport sink (input valid, command, point_x, point_y, point_z, point_color,
                 output ready);
endinterface

interface psr_rsp_if;
   import psr_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIX_X_W-1:0] pixel_x;
   logic [PIX_Y_W-1:0] pixel_y;
   logic [COLOR_W-1:0] pixel_color;
   logic               last_pixel;
   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

interface psr_csr_if;
   import psr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/psr_mac.sv -----
// Shared signed multiply-accumulate: acc = a1*b1 +/- a2*b2 on one multiplier, in phases IDLE, SECOND, SUM.
// Depends on psr_pkg.
module psr_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  psr_pkg::mac_ctl_type                  ctl,
   input  logic signed [psr_pkg::MAC_A_W-1:0]    a1,
   input  logic signed [psr_pkg::MAC_B_W-1:0]    b1,
   input  logic signed [psr_pkg::MAC_A_W-1:0]    a2,
   input  logic signed [psr_pkg::MAC_B_W-1:0]    b2,
   output logic signed [psr_pkg::MAC_ACC_W-1:0]  acc,
   output logic                                  done
);
   import psr_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_SUM    = 2'd2;

   logic [1:0]                  phase_ff, phase_in;
   logic                        done_ff, done_in;
   logic                        sub_ff, sub_in;
   logic signed [MAC_A_W-1:0]   a2_ff, a2_in;
   logic signed [MAC_B_W-1:0]   b2_ff, b2_in;
   logic signed [MAC_P_W-1:0]   prod_ff, prod_in;
   logic signed [MAC_ACC_W-1:0] acc_ff, acc_in;
   logic signed [MAC_A_W-1:0]   mul_a;
   logic signed [MAC_B_W-1:0]   mul_b;

   // select the multiplier operands for this phase
   always_comb begin
      mul_a = (phase_ff == PH_SECOND) ? a2_ff : a1;
      mul_b = (phase_ff == PH_SECOND) ? b2_ff : b1;
   end

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      sub_in   = sub_ff;
      a2_in    = a2_ff;
      b2_in    = b2_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (ctl.start) begin
               prod_in  = mul_a * mul_b;
               a2_in    = a2;
               b2_in    = b2;
               sub_in   = ctl.sub;
               phase_in = PH_SECOND;
            end
         end
         PH_SECOND: begin
            acc_in   = MAC_ACC_W'(prod_ff);
            prod_in  = mul_a * mul_b;
            phase_in = PH_SUM;
         end
         PH_SUM: begin
            acc_in   = sub_ff ? acc_ff - MAC_ACC_W'(prod_ff) : acc_ff + MAC_ACC_W'(prod_ff);
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sub_ff  <= sub_in;
      a2_ff   <= a2_in;
      b2_ff   <= b2_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

// ----- sv/psr_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on psr_pkg.
module psr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [psr_pkg::DIV_N_W-1:0]    num,
   input  logic [psr_pkg::DIV_D_W-1:0]    den,
   output logic [psr_pkg::DIV_N_W-1:0]    quo,
   output logic                           done
);
   import psr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 fits;

   // shift in the next numerator bit and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_N_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_N_W);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// ----- sv/psr_dmem.sv -----
// Depth buffer memory: one write port, one read port with registered read data.
// Depends on psr_pkg.
module psr_dmem #(
   parameter int CELLS = 32768,
   parameter int AW    = 15
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [AW-1:0]                 waddr,
   input  logic [psr_pkg::DEPTH_W-1:0]   wdata,
   input  logic [AW-1:0]                 raddr,
   output logic [psr_pkg::DEPTH_W-1:0]   rdata
);
   import psr_pkg::*;

   logic [DEPTH_W-1:0] mem [CELLS];
   logic [DEPTH_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/point_splat_depth_rasterizer_top.sv -----
// Point splat depth rasterizer: rotate, project, splat and depth-test one point at a time.
// A point runs six rotation products on the shared MAC, then two zoom products with a divide
// after each, then walks its covered pixels; the walk can hold while rsp stalls.
// A clear writes all SCREEN_WIDTH*SCREEN_HEIGHT depth entries (32768 at default), one depth entry a cycle.
// Reset is synchronous: control and configuration registers take their reset values and the same
// clear sweep runs, with req.ready low; register writes are taken during the sweep, not while in reset.
module point_splat_depth_rasterizer_top #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic          clock,
   input  logic          reset,
   psr_req_if.sink       req,
   psr_rsp_if.source     rsp,
   psr_csr_if.sink       csr
);
   import psr_pkg::*;

   localparam int XW     = $clog2(SCREEN_WIDTH);
   localparam int YW     = $clog2(SCREEN_HEIGHT);
   localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW     = $clog2(CELLS);
   localparam int POS_W  = 48;
   localparam logic signed [POS_W-1:0] CX    = POS_W'(SCREEN_WIDTH / 2);
   localparam logic signed [POS_W-1:0] CY    = POS_W'(SCREEN_HEIGHT / 2);
   localparam logic signed [POS_W-1:0] W_LIM = POS_W'(SCREEN_WIDTH);
   localparam logic signed [POS_W-1:0] H_LIM = POS_W'(SCREEN_HEIGHT);
   localparam logic signed [MAC_A_W-1:0] D_MIN = 28'sd26;

   // sequencer states
   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_MSTART = 4'd2;
   localparam logic [3:0] ST_MWAIT  = 4'd3;
   localparam logic [3:0] ST_DEPTH  = 4'd4;
   localparam logic [3:0] ST_DSTART = 4'd5;
   localparam logic [3:0] ST_DWAIT  = 4'd6;
   localparam logic [3:0] ST_PIX    = 4'd7;
   localparam logic [3:0] ST_CMP    = 4'd8;
   localparam logic [3:0] ST_FLUSH  = 4'd9;

   // MAC operations in order
   localparam logic [2:0] OP_X1 = 3'd0;
   localparam logic [2:0] OP_Z1 = 3'd1;
   localparam logic [2:0] OP_Y2 = 3'd2;
   localparam logic [2:0] OP_Z2 = 3'd3;
   localparam logic [2:0] OP_X3 = 3'd4;
   localparam logic [2:0] OP_Y3 = 3'd5;
   localparam logic [2:0] OP_ZX = 3'd6;
   localparam logic [2:0] OP_ZY = 3'd7;

   // configuration registers
   logic [31:0]           yaw_ff, pitch_ff, roll_ff;
   logic [CSR_DATA_W-1:0] offset_ff;
   logic [DIST_W-1:0]     dist_ff;
   logic [ZOOM_W-1:0]     zoom_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic                  axis_ff;

   // control
   logic [3:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [MAC_A_W-1:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic signed [MAC_A_W-1:0] x1_ff, x1_in, z1_ff, z1_in, y2_ff, y2_in;
   logic signed [MAC_A_W-1:0] z2_ff, z2_in, x3_ff, x3_in, y3_ff, y3_in;
   logic signed [MAC_A_W-1:0] d_ff, d_in;
   logic [COLOR_W-1:0]        color_ff, color_in;
   logic                      pix_only_ff, pix_only_in;
   logic [1:0]                rad_ff, rad_in;
   logic                      neg_ff, neg_in;
   logic signed [POS_W-1:0]   sxo_ff, sxo_in, syo_ff, syo_in;
   logic signed [2:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic [PIX_X_W-1:0]        cpx_ff, cpx_in, pend_px_ff, pend_px_in, rsp_px_ff, rsp_px_in;
   logic [PIX_Y_W-1:0]        cpy_ff, cpy_in, pend_py_ff, pend_py_in, rsp_py_ff, rsp_py_in;
   logic [COLOR_W-1:0]        rsp_color_ff, rsp_color_in;
   logic                      rsp_last_ff, rsp_last_in;

   // datapath nets
   logic signed [COORD_W:0]    tx, ty, tz;
   logic signed [MAC_B_W-1:0]  sy, cy, sp, cp, sr, cr, zm;
   mac_ctl_type                mac_ctl;
   logic signed [MAC_A_W-1:0]  mac_a1, mac_a2;
   logic signed [MAC_B_W-1:0]  mac_b1, mac_b2;
   logic signed [MAC_ACC_W-1:0] mac_acc;
   logic                       mac_done;
   logic signed [MAC_A_W-1:0]  rot_res;
   logic signed [MAC_ACC_W-1:0] acc_mag;
   logic                       div_start, div_done;
   logic [DIV_N_W-1:0]         div_quo;
   logic signed [POS_W-1:0]    quo_s, quo_signed, pos_res;
   logic signed [MAC_A_W-1:0]  d_calc;
   logic                       visible;
   logic signed [MAC_A_W:0]    gain_gap;
   logic [31:0]                gain25, depth10;
   logic [1:0]                 rad_calc;
   logic signed [2:0]          rad_s;
   logic signed [POS_W-1:0]    px_s, py_s;
   logic                       in_bounds;
   logic [AW-1:0]              pix_addr;
   logic                       walk_last;
   logic signed [2:0]          dx_next, dy_next;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [DEPTH_W-1:0]         mem_wdata, mem_rdata;
   logic                       win, slot_free, stall, push, push_last;

   // translate and remap the incoming point
   always_comb begin
      tx = COORD_W'(req.point_x) - $signed(offset_ff[COORD_W-1:0]);
      ty = COORD_W'(req.point_y) - $signed(offset_ff[2*COORD_W-1:COORD_W]);
      tz = COORD_W'(req.point_z) - $signed(offset_ff[3*COORD_W-1:2*COORD_W]);
      tx = (COORD_W+1)'($signed(req.point_x)) - (COORD_W+1)'($signed(offset_ff[COORD_W-1:0]));
      ty = (COORD_W+1)'($signed(req.point_y))
         - (COORD_W+1)'($signed(offset_ff[2*COORD_W-1:COORD_W]));
      tz = (COORD_W+1)'($signed(req.point_z))
         - (COORD_W+1)'($signed(offset_ff[3*COORD_W-1:2*COORD_W]));
   end

   // trig factors and zoom as MAC operands
   always_comb begin
      sy = MAC_B_W'($signed(yaw_ff[31:16]));
      cy = MAC_B_W'($signed(yaw_ff[15:0]));
      sp = MAC_B_W'($signed(pitch_ff[31:16]));
      cp = MAC_B_W'($signed(pitch_ff[15:0]));
      sr = MAC_B_W'($signed(roll_ff[31:16]));
      cr = MAC_B_W'($signed(roll_ff[15:0]));
      zm = $signed({1'b0, zoom_ff});
   end

   // MAC operand select by operation
   always_comb begin
      mac_a1      = rx_ff;
      mac_b1      = cy;
      mac_a2      = rz_ff;
      mac_b2      = sy;
      mac_ctl.sub = 1'b0;
      case (op_ff)
         OP_X1: begin
            mac_a1 = rx_ff; mac_b1 = cy; mac_a2 = rz_ff; mac_b2 = sy;
         end
         OP_Z1: begin
            mac_a1 = rz_ff; mac_b1 = cy; mac_a2 = rx_ff; mac_b2 = sy; mac_ctl.sub = 1'b1;
         end
         OP_Y2: begin
            mac_a1 = ry_ff; mac_b1 = cp; mac_a2 = z1_ff; mac_b2 = sp; mac_ctl.sub = 1'b1;
         end
         OP_Z2: begin
            mac_a1 = ry_ff; mac_b1 = sp; mac_a2 = z1_ff; mac_b2 = cp;
         end
         OP_X3: begin
            mac_a1 = x1_ff; mac_b1 = cr; mac_a2 = y2_ff; mac_b2 = sr; mac_ctl.sub = 1'b1;
         end
         OP_Y3: begin
            mac_a1 = x1_ff; mac_b1 = sr; mac_a2 = y2_ff; mac_b2 = cr;
         end
         OP_ZX: begin
            mac_a1 = x3_ff; mac_b1 = zm; mac_a2 = '0; mac_b2 = '0;
         end
         default: begin
            mac_a1 = y3_ff; mac_b1 = zm; mac_a2 = '0; mac_b2 = '0;
         end
      endcase
      mac_ctl.start = (state_ff == ST_MSTART);
   end

   psr_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .a1    (mac_a1),
      .b1    (mac_b1),
      .a2    (mac_a2),
      .b2    (mac_b2),
      .acc   (mac_acc),
      .done  (mac_done)
   );

   // rotation result: floor shift by the trig fraction
   assign rot_res = mac_acc[TRIG_FRAC+MAC_A_W-1:TRIG_FRAC];

   // divider takes the magnitude of the zoomed coordinate
   assign acc_mag   = mac_acc[MAC_ACC_W-1] ? -mac_acc : mac_acc;
   assign div_start = (state_ff == ST_DSTART);

   psr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_mag[DIV_N_W-1:0]),
      .den   (d_ff[DIV_D_W-1:0]),
      .quo   (div_quo),
      .done  (div_done)
   );

   // truncating quotient, then screen position
   always_comb begin
      quo_s      = $signed(POS_W'(div_quo));
      quo_signed = neg_ff ? -quo_s : quo_s;
      pos_res    = ((op_ff == OP_ZX) ? CX : CY) + quo_signed;
   end

   // depth, visibility and splat radius
   always_comb begin
      d_calc   = z2_ff + $signed(MAC_A_W'(dist_ff));
      visible  = d_calc >= D_MIN;
      gain_gap = $signed((MAC_A_W+1)'(gain_ff)) - (MAC_A_W+1)'(d_calc);
      gain25   = (32'(gain_ff) << 4) + (32'(gain_ff) << 3) + 32'(gain_ff);
      depth10  = (32'(d_calc[DIV_D_W-1:0]) << 3) + (32'(d_calc[DIV_D_W-1:0]) << 1) + 32'd256;
      if (pix_only_ff) begin
         rad_calc = 2'd0;
      end else if (gain_gap >= (MAC_A_W+1)'(D_MIN)) begin
         rad_calc = 2'd2;
      end else if (gain25 > depth10) begin
         rad_calc = 2'd1;
      end else begin
         rad_calc = 2'd0;
      end
   end

   // current pixel of the splat walk
   always_comb begin
      rad_s     = $signed({1'b0, rad_ff});
      px_s      = sxo_ff + POS_W'(dx_ff);
      py_s      = syo_ff + POS_W'(dy_ff);
      in_bounds = (px_s >= 0) && (px_s < W_LIM) && (py_s >= 0) && (py_s < H_LIM);
      pix_addr  = AW'(py_s[YW-1:0]) * AW'(SCREEN_WIDTH) + AW'(px_s[XW-1:0]);
      walk_last = (dx_ff == rad_s) && (dy_ff == rad_s);
      if (dx_ff == rad_s) begin
         dx_next = -rad_s;
         dy_next = dy_ff + 3'sd1;
      end else begin
         dx_next = dx_ff + 3'sd1;
         dy_next = dy_ff;
      end
   end

   // depth test and result hand-off
   always_comb begin
      win       = (state_ff == ST_CMP) && ($signed({8'b0, mem_rdata}) > d_ff);
      slot_free = !rsp_valid_ff || rsp.ready;
      stall     = win && pend_ff && !slot_free;
      push_last = (state_ff == ST_FLUSH) && pend_ff && slot_free;
      push      = (win && pend_ff && slot_free) || push_last;
      mem_we    = (state_ff == ST_CLEAR) || (win && !stall);
      mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
      mem_wdata = (state_ff == ST_CLEAR) ? DEPTH_CLEAR : d_ff[DEPTH_W-1:0];
   end

   psr_dmem #(
      .CELLS (CELLS),
      .AW    (AW)
   ) u_dmem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (pix_addr),
      .rdata (mem_rdata)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      clr_in      = clr_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      rz_in       = rz_ff;
      x1_in       = x1_ff;
      z1_in       = z1_ff;
      y2_in       = y2_ff;
      z2_in       = z2_ff;
      x3_in       = x3_ff;
      y3_in       = y3_ff;
      d_in        = d_ff;
      color_in    = color_ff;
      pix_only_in = pix_only_ff;
      rad_in      = rad_ff;
      neg_in      = neg_ff;
      sxo_in      = sxo_ff;
      syo_in      = syo_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      addr_in     = addr_ff;
      cpx_in      = cpx_ff;
      cpy_in      = cpy_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               color_in    = req.point_color;
               pix_only_in = (req.command == CMD_PIXEL);
               op_in       = OP_X1;
               if (axis_ff) begin
                  rx_in = MAC_A_W'(tx);
                  ry_in = MAC_A_W'(ty);
                  rz_in = MAC_A_W'(tz);
               end else begin
                  rx_in = -MAC_A_W'(ty);
                  ry_in = -MAC_A_W'(tz);
                  rz_in = MAC_A_W'(tx);
               end
               case (req.command)
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_SPLAT, CMD_PIXEL: begin
                     state_in = ST_MSTART;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MSTART: begin
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mac_done) begin
               case (op_ff)
                  OP_X1:   x1_in = rot_res;
                  OP_Z1:   z1_in = rot_res;
                  OP_Y2:   y2_in = rot_res;
                  OP_Z2:   z2_in = rot_res;
                  OP_X3:   x3_in = rot_res;
                  OP_Y3:   y3_in = rot_res;
                  default: neg_in = mac_acc[MAC_ACC_W-1];
               endcase
               if (op_ff == OP_Y3) begin
                  state_in = ST_DEPTH;
               end else if (op_ff == OP_ZX || op_ff == OP_ZY) begin
                  state_in = ST_DSTART;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = ST_MSTART;
               end
            end
         end
         ST_DEPTH: begin
            d_in   = d_calc;
            rad_in = rad_calc;
            op_in  = OP_ZX;
            state_in = visible ? ST_MSTART : ST_IDLE;
         end
         ST_DSTART: begin
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               if (op_ff == OP_ZX) begin
                  sxo_in   = pos_res;
                  op_in    = OP_ZY;
                  state_in = ST_MSTART;
               end else begin
                  syo_in   = pos_res;
                  dx_in    = -$signed({1'b0, rad_ff});
                  dy_in    = -$signed({1'b0, rad_ff});
                  state_in = ST_PIX;
               end
            end
         end
         ST_PIX: begin
            addr_in = pix_addr;
            cpx_in  = px_s[PIX_X_W-1:0];
            cpy_in  = py_s[PIX_Y_W-1:0];
            if (in_bounds) begin
               state_in = ST_CMP;
            end else begin
               dx_in    = dx_next;
               dy_in    = dy_next;
               state_in = walk_last ? ST_FLUSH : ST_PIX;
            end
         end
         ST_CMP: begin
            if (!stall) begin
               dx_in    = dx_next;
               dy_in    = dy_next;
               state_in = walk_last ? ST_FLUSH : ST_PIX;
            end
         end
         ST_FLUSH: begin
            if (!pend_ff || slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // pending winner and output register
   always_comb begin
      pend_in      = pend_ff;
      pend_px_in   = pend_px_ff;
      pend_py_in   = pend_py_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_py_in    = rsp_py_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_px_in    = pend_px_ff;
         rsp_py_in    = pend_py_ff;
         rsp_color_in = color_ff;
         rsp_last_in  = push_last;
      end
      if (win && !stall) begin
         pend_in    = 1'b1;
         pend_px_in = cpx_ff;
         pend_py_in = cpy_ff;
      end else if (push_last) begin
         pend_in = 1'b0;
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         op_ff        <= OP_X1;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rz_ff        <= rz_in;
      x1_ff        <= x1_in;
      z1_ff        <= z1_in;
      y2_ff        <= y2_in;
      z2_ff        <= z2_in;
      x3_ff        <= x3_in;
      y3_ff        <= y3_in;
      d_ff         <= d_in;
      color_ff     <= color_in;
      pix_only_ff  <= pix_only_in;
      rad_ff       <= rad_in;
      neg_ff       <= neg_in;
      sxo_ff       <= sxo_in;
      syo_ff       <= syo_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      addr_ff      <= addr_in;
      cpx_ff       <= cpx_in;
      cpy_ff       <= cpy_in;
      pend_px_ff   <= pend_px_in;
      pend_py_ff   <= pend_py_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff    <= 32'd16384;
         pitch_ff  <= 32'd16384;
         roll_ff   <= 32'd16384;
         offset_ff <= '0;
         dist_ff   <= 20'd1280;
         zoom_ff   <= 16'd64;
         gain_ff   <= 11'd256;
         axis_ff   <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_YAW:    yaw_ff    <= csr.data[31:0];
            REG_PITCH:  pitch_ff  <= csr.data[31:0];
            REG_ROLL:   roll_ff   <= csr.data[31:0];
            REG_OFFSET: offset_ff <= csr.data;
            REG_DIST:   dist_ff   <= csr.data[DIST_W-1:0];
            REG_ZOOM:   zoom_ff   <= csr.data[ZOOM_W-1:0];
            REG_GAIN:   gain_ff   <= csr.data[GAIN_W-1:0];
            REG_AXIS:   axis_ff   <= csr.data[0];
            default:    axis_ff   <= axis_ff;
         endcase
      end
   end

   assign csr.ready       = 1'b1;
   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_x     = rsp_px_ff;
   assign rsp.pixel_y     = rsp_py_ff;
   assign rsp.pixel_color = rsp_color_ff;
   assign rsp.last_pixel  = rsp_last_ff;

endmodule

// ----- sv/psr_checker.sv -----
// Port-level checker for the point splat rasterizer, bound to the top level.
// Depends on psr_pkg and point_splat_depth_rasterizer_top_macros.svh.
`include "point_splat_depth_rasterizer_top_macros.svh"

module psr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [psr_pkg::CMD_W-1:0]     req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [psr_pkg::PIX_X_W-1:0]   rsp_pixel_x,
   input logic [psr_pkg::PIX_Y_W-1:0]   rsp_pixel_y,
   input logic [psr_pkg::COLOR_W-1:0]   rsp_pixel_color,
   input logic                          rsp_last_pixel
);
   import psr_pkg::*;

   // a stalled response transaction stays put
   `PSR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `PSR_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last_pixel))
   // any real command keeps the block busy in the next cycle
   `PSR_ASSERT_NEXT(a_busy_after_cmd, req_valid && req_ready && (req_command == CMD_CLEAR || req_command == CMD_SPLAT || req_command == CMD_PIXEL), !req_ready)
   // reset starts the clearing sweep with nothing on the output
   `PSR_ASSERT_NEXT_ALWAYS(a_reset_sweep, reset, !req_ready && !rsp_valid)

endmodule

bind point_splat_depth_rasterizer_top psr_checker u_psr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_command     (req.command),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_pixel_x     (rsp.pixel_x),
   .rsp_pixel_y     (rsp.pixel_y),
   .rsp_pixel_color (rsp.pixel_color),
   .rsp_last_pixel  (rsp.last_pixel)
);

// ----- tb/point_splat_depth_rasterizer_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the point splat depth rasterizer: tracks register writes, projects each
// accepted point into expected pixels against its own depth buffer, and checks every pixel.
// Depends on psr_pkg and the channel interfaces in psr_if.sv.
module point_splat_depth_rasterizer_checker (
   input  logic clock,
   input  logic reset,
   psr_req_if   req,
   psr_rsp_if   rsp,
   psr_csr_if   csr,
   output int   errors,
   output int   pending,
   output int   pixels_checked
);
   import psr_pkg::*;

   localparam int SCR_W = 256;
   localparam int SCR_H = 128;

   typedef struct packed {
      logic [PIX_X_W-1:0] x;
      logic [PIX_Y_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_t;

   logic [31:0]           yaw_sc, pitch_sc, roll_sc;
   logic [CSR_DATA_W-1:0] view_off;
   logic [DIST_W-1:0]     view_dist;
   logic [ZOOM_W-1:0]     zoom;
   logic [GAIN_W-1:0]     gain;
   logic                  keep_axes;
   logic [DEPTH_W-1:0]    zbuf [SCR_W*SCR_H];
   pixel_t                drawn_q[$];

   initial begin
      errors = 0;
      pending = 0;
      pixels_checked = 0;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic clear_depth();
      for (int i = 0; i < SCR_W*SCR_H; i++) zbuf[i] = DEPTH_CLEAR;
   endtask

   // Project one point and queue the pixels that win the depth test
   task automatic draw_point(input logic [CMD_W-1:0] cmd, input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic signed [COORD_W-1:0] pz, input logic [COLOR_W-1:0] col);
      logic signed [COORD_W-1:0] ox, oy, oz;
      logic signed [15:0] s16;
      longint tx, ty, tz, rx, ry, rz, ys, yc, ps, pc, rs, rc;
      longint x1, z1, y2, z2, x3, y3, d, sxo, syo, r, row, colm;
      int n, idx;
      pixel_t p;
      ox = view_off[19:0];
      oy = view_off[39:20];
      oz = view_off[59:40];
      tx = longint'(px) - longint'(ox);
      ty = longint'(py) - longint'(oy);
      tz = longint'(pz) - longint'(oz);
      if (keep_axes) begin
         rx = tx; ry = ty; rz = tz;
      end else begin
         rx = -ty; ry = -tz; rz = tx;
      end
      s16 = yaw_sc[31:16];   ys = s16;  s16 = yaw_sc[15:0];   yc = s16;
      s16 = pitch_sc[31:16]; ps = s16;  s16 = pitch_sc[15:0]; pc = s16;
      s16 = roll_sc[31:16];  rs = s16;  s16 = roll_sc[15:0];  rc = s16;
      x1 = (rx * yc + rz * ys) >>> TRIG_FRAC;
      z1 = (rz * yc - rx * ys) >>> TRIG_FRAC;
      y2 = (ry * pc - z1 * ps) >>> TRIG_FRAC;
      z2 = (ry * ps + z1 * pc) >>> TRIG_FRAC;
      x3 = (x1 * rc - y2 * rs) >>> TRIG_FRAC;
      y3 = (x1 * rs + y2 * rc) >>> TRIG_FRAC;
      d = z2 + longint'(view_dist);
      // drop points at or behind the near plane
      if (!(10 * d > 256)) return;
      sxo = SCR_W / 2 + (longint'(zoom) * x3) / d;
      syo = SCR_H / 2 + (longint'(zoom) * y3) / d;
      if (cmd == CMD_PIXEL) r = 0;
      else if (10 * longint'(gain) > 10 * d + 256) r = 2;
      else if (25 * longint'(gain) > 10 * d + 256) r = 1;
      else r = 0;
      n = 0;
      for (longint dy = -r; dy <= r; dy++) begin
         row = syo + dy;
         if (row < 0 || row >= SCR_H) continue;
         for (longint dx = -r; dx <= r; dx++) begin
            colm = sxo + dx;
            if (colm < 0 || colm >= SCR_W) continue;
            idx = int'(row) * SCR_W + int'(colm);
            if (d < longint'(zbuf[idx])) begin
               zbuf[idx] = (d > 1048575) ? 20'hFFFFF : d[DEPTH_W-1:0];
               p.x = colm[PIX_X_W-1:0];
               p.y = row[PIX_Y_W-1:0];
               p.color = col;
               p.last = 1'b0;
               drawn_q.push_back(p);
               n++;
            end
         end
      end
      if (n > 0) drawn_q[drawn_q.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      pixel_t want;
      if (reset) begin
         yaw_sc = 32'd16384;
         pitch_sc = 32'd16384;
         roll_sc = 32'd16384;
         view_off = '0;
         view_dist = 20'd1280;
         zoom = 16'd64;
         gain = 11'd256;
         keep_axes = 1'b0;
         clear_depth();
         drawn_q.delete();
      end else begin
         // compare each pixel transaction with the oldest expectation
         if (rsp.valid && rsp.ready) begin
            if (drawn_q.size() == 0) begin
               report("unexpected pixel, x", rsp.pixel_x, -1);
            end else begin
               want = drawn_q.pop_front();
               pixels_checked++;
               if (rsp.pixel_x !== want.x) report("pixel_x", rsp.pixel_x, want.x);
               if (rsp.pixel_y !== want.y) report("pixel_y", rsp.pixel_y, want.y);
               if (rsp.pixel_color !== want.color)
                  report("pixel_color", rsp.pixel_color, want.color);
               if (rsp.last_pixel !== want.last)
                  report("last_pixel", rsp.last_pixel, want.last);
            end
         end
         if (req.valid && req.ready) begin
            case (req.command)
               CMD_CLEAR: clear_depth();
               CMD_SPLAT, CMD_PIXEL:
                  draw_point(req.command, req.point_x, req.point_y, req.point_z,
                             req.point_color);
               default: ;
            endcase
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_YAW:    yaw_sc = csr.data[31:0];
               REG_PITCH:  pitch_sc = csr.data[31:0];
               REG_ROLL:   roll_sc = csr.data[31:0];
               REG_OFFSET: view_off = csr.data;
               REG_DIST:   view_dist = csr.data[DIST_W-1:0];
               REG_ZOOM:   zoom = csr.data[ZOOM_W-1:0];
               REG_GAIN:   gain = csr.data[GAIN_W-1:0];
               REG_AXIS:   keep_axes = csr.data[0];
               default: ;
            endcase
         end
      end
      pending = drawn_q.size();
   end
endmodule

// ----- tb/point_splat_depth_rasterizer_top_tb.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for point_splat_depth_rasterizer_top: directed points, then phases of
// random points under varied view registers. Depends on psr_pkg, psr_if.sv and the checker.
module point_splat_depth_rasterizer_top_tb;
   import psr_pkg::*;

   localparam int LIMIT = 2000000;
   localparam int SETTLE = 400;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_fire = 1'b0;
   logic csr_fire = 1'b0;
   logic gaps_on = 1'b1;
   logic long_hold = 1'b0;
   int   cycles = 0;
   int   items_sent = 0;
   int   clears_sent = 0;
   int   errors, pending, pixels_checked;

   psr_req_if req ();
   psr_rsp_if rsp ();
   psr_csr_if csr ();

   point_splat_depth_rasterizer_top DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   point_splat_depth_rasterizer_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .errors(errors), .pending(pending), .pixels_checked(pixels_checked)
   );

   always #5 clock = ~clock;

   // capture handshakes at the edge so the drivers read them race-free
   always @(posedge clock) begin
      req_fire <= req.valid && req.ready;
      csr_fire <= csr.valid && csr.ready;
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding", cycles, pending);
         $display("FAIL point_splat_depth_rasterizer_top");
         $finish;
      end
   end

   // pixel receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp.ready = 1'b0;
            repeat (3000) @(negedge clock);
            long_hold = 1'b0;
            rsp.ready = 1'b1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp.ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp.ready = 1'b1;
         end else begin
            rsp.ready = 1'b1;
         end
      end
   end

   task automatic send_point(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                             input logic [COLOR_W-1:0] col);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req.command = cmd;
      req.point_x = x;
      req.point_y = y;
      req.point_z = z;
      req.point_color = col;
      req.valid = 1'b1;
      do @(negedge clock); while (!req_fire);
      items_sent++;
      if (cmd == CMD_CLEAR) clears_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr.index = idx;
      csr.data = val;
      csr.valid = 1'b1;
      do @(negedge clock); while (!csr_fire);
   endtask

   // hold until every expected pixel is out and the block has settled
   task automatic wait_idle();
      req.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 32'h0000_4000;
         1: return 32'h2D41_2D41;
         2: return 32'h4000_0000;
         3: return 32'hD2BF_2D41;
         4: return 32'h2000_376D;
         default: return 32'hE000_C893;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(input int span);
      int v;
      v = $urandom_range(0, 2 * span) - span;
      return v[COORD_W-1:0];
   endfunction

   // mostly near, on-screen points; some full-range noise, a few idle commands and a clear when asked
   task automatic random_point(input logic allow_clear);
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] x, y, z;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) cmd = CMD_NONE;
      else if (pick < 25) cmd = CMD_PIXEL;
      else cmd = CMD_SPLAT;
      if (allow_clear) cmd = CMD_CLEAR;
      if ($urandom_range(0, 9) == 0) begin
         x = $urandom; y = $urandom; z = $urandom;
      end else begin
         x = near_coord(768); y = near_coord(768); z = near_coord(768);
      end
      send_point(cmd, x, y, z, $urandom);
   endtask

   task automatic set_view(input int phase);
      logic [CSR_DATA_W-1:0] off;
      off = {near_coord(256), near_coord(256), near_coord(256)};
      case (phase)
         1: begin
            write_reg(REG_AXIS, 60'd1);
            write_reg(REG_YAW, 60'h2D41_2D41);
            write_reg(REG_GAIN, 60'd1280);
         end
         2: begin
            write_reg(REG_AXIS, 60'd0);
            write_reg(REG_YAW, pick_angle());
            write_reg(REG_PITCH, pick_angle());
            write_reg(REG_ROLL, pick_angle());
            write_reg(REG_OFFSET, off);
            write_reg(REG_ZOOM, 60'd100);
            write_reg(REG_GAIN, 60'd26);
         end
         3: begin
            write_reg(REG_ZOOM, 60'd0);
            write_reg(REG_GAIN, 60'd0);
         end
         4: begin
            write_reg(REG_DIST, 60'd0);
            write_reg(REG_ZOOM, 60'd65535);
            write_reg(REG_GAIN, 60'd2047);
         end
         5: begin
            write_reg(REG_DIST, 60'd1048575);
            write_reg(REG_OFFSET, 60'hFFF_FFFF_FFFF_FFFF);
            write_reg(REG_YAW, 60'hFFFF_FFFF);
            write_reg(REG_PITCH, 60'hFFFF_FFFF);
            write_reg(REG_ROLL, 60'hFFFF_FFFF);
         end
         6: begin
            write_reg(REG_YAW, 60'd0);
            write_reg(REG_PITCH, 60'd0);
            write_reg(REG_ROLL, 60'd0);
            write_reg(REG_OFFSET, 60'd0);
            write_reg(REG_DIST, 60'd1280);
            write_reg(REG_ZOOM, 60'd64);
            write_reg(REG_GAIN, 60'd512);
         end
         default: begin
            write_reg(REG_AXIS, {59'd0, 1'($urandom)});
            write_reg(REG_YAW, pick_angle());
            write_reg(REG_PITCH, pick_angle());
            write_reg(REG_ROLL, pick_angle());
            write_reg(REG_OFFSET, off);
            write_reg(REG_GAIN, 60'd700);
         end
      endcase
      csr.valid = 1'b0;
   endtask

   initial begin
      req.valid = 1'b0;
      req.command = CMD_NONE;
      req.point_x = '0;
      req.point_y = '0;
      req.point_z = '0;
      req.point_color = '0;
      csr.valid = 1'b0;
      csr.index = REG_YAW;
      csr.data = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed: default view, depth 5.0 straight ahead, zoom 64, gain 1.0
      send_point(CMD_SPLAT, 20'd0, 20'd0, 20'd0, 24'h123456);
      send_point(CMD_SPLAT, 20'd0, 20'd0, 20'd0, 24'h654321);        // occluded
      send_point(CMD_PIXEL, -20'sd1200, 20'd0, 20'd0, 24'hFFFFFF);   // closer, single pixel
      send_point(CMD_SPLAT, -20'sd1200, 20'd0, 20'd0, 24'h000000);   // full 5x5, centre loses
      send_point(CMD_NONE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF);
      send_point(CMD_SPLAT, -20'sd1280, 20'd0, 20'd0, 24'h0000FF);   // depth zero
      send_point(CMD_SPLAT, -20'sd1255, 20'd0, 20'd0, 24'h00FF00);   // just below near plane
      send_point(CMD_SPLAT, -20'sd1254, 20'd0, 20'd0, 24'hFF0000);   // just above near plane
      send_point(CMD_SPLAT, -20'sd1200, 20'sd160, -20'sd80, 24'hA5A5A5); // clipped corner
      send_point(CMD_SPLAT, -20'sd1200, -20'sd160, 20'sd80, 24'h5A5A5A); // opposite corner
      send_point(CMD_SPLAT, 20'h7FFFF, 20'h80000, 20'h7FFFF, 24'hFFFFFF);
      send_point(CMD_SPLAT, 20'h80000, 20'h7FFFF, 20'h80000, 24'h000000);
      send_point(CMD_SPLAT, 20'd0, 20'h7FFFF, 20'h80000, 24'h0F0F0F); // off screen
      send_point(CMD_CLEAR, 20'd0, 20'd0, 20'd0, 24'd0);
      send_point(CMD_SPLAT, 20'd0, 20'd0, 20'd0, 24'h123456);        // wins after clear
      send_point(CMD_PIXEL, 20'd100, -20'sd50, 20'd30, 24'hC0FFEE);

      // random phases, each after the first under a new view once the block is idle
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            wait_idle();
            set_view(ph);
         end
         if (ph == PHASES - 1) gaps_on = 1'b0;
         if (ph == 1) long_hold = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_point((ph == 2 || ph == 5) && i == 20);
      end

      wait_idle();
      $display("ran %0d point transactions (%0d clears) over %0d view settings",
               items_sent, clears_sent, PHASES);
      $display("checked %0d pixels, %0d mismatches", pixels_checked, errors);
      if (errors == 0) begin
         $display("PASS point_splat_depth_rasterizer_top");
      end else begin
         $display("FAIL point_splat_depth_rasterizer_top");
      end
      $finish;
   end
endmodule
